/* rtl/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the SHA-1 stream hasher modules.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned SCHED_LEN  = 16;

    typedef logic [6:0] t_round;
    typedef logic [5:0] t_pos;

    localparam t_round LAST_ROUND = t_round'(NUM_ROUNDS - 1);
    localparam t_pos   LAST_POS   = 6'd63;
    localparam t_pos   LEN_POS    = 6'd56;

    localparam logic [31:0] H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic       byte_wr;
        logic [7:0] byte_val;
        logic       word_end;
        logic       step;
    } t_sched_ctl;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

/* rtl/sha1_round.sv */
// ----------------------------------------------------------------------------
// sha1_round
// One SHA-1 round: round function, constant selection and the five-way add.
// ----------------------------------------------------------------------------
module sha1_round (
    input  sha1_pkg::t_work  i_work,
    input  logic [31:0]      i_w,
    input  sha1_pkg::t_round i_round,
    output sha1_pkg::t_work  o_work
);
    import sha1_pkg::*;

    logic [31:0] f;
    logic [31:0] k;

    always_comb begin
        priority if (i_round < t_round'(20)) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = K_00_19;
        end else if (i_round < t_round'(40)) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_20_39;
        end else if (i_round < t_round'(60)) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = K_40_59;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_60_79;
        end
    end

    always_comb begin
        o_work.a = rotl(i_work.a, 5) + f + i_work.e + k + i_w;
        o_work.b = i_work.a;
        o_work.c = rotl(i_work.b, 30);
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

/* rtl/sha1_sched.sv */
// ----------------------------------------------------------------------------
// sha1_sched
// Block buffer and rolling message schedule as one 16-word shift line.
// Bytes pack big-endian into words that shift in at the top; each round
// shifts once and feeds the expanded word back in.
// ----------------------------------------------------------------------------
module sha1_sched (
    input  logic                 i_clk,
    input  sha1_pkg::t_sched_ctl i_ctl,
    output logic [31:0]          o_w
);
    import sha1_pkg::*;

    logic [23:0] r_acc;
    logic [31:0] r_line [SCHED_LEN];
    logic [31:0] expand;

    assign expand = rotl(r_line[13] ^ r_line[8] ^ r_line[2] ^ r_line[0], 1);
    assign o_w    = r_line[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_wr) begin
            r_acc <= {r_acc[15:0], i_ctl.byte_val};
        end
        if (i_ctl.step || (i_ctl.byte_wr && i_ctl.word_end)) begin
            for (int i = 0; i < SCHED_LEN - 1; i++) begin
                r_line[i] <= r_line[i + 1];
            end
            r_line[SCHED_LEN - 1] <= i_ctl.step ? expand : {r_acc, i_ctl.byte_val};
        end
    end

endmodule

/* rtl/sha1_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream, one byte per transfer.
// The byte that fills a 64-byte block stalls the input while the 80 rounds
// run on the shared round unit and the chaining add is made. The last item
// pads one byte per cycle, pausing while a full block is hashed (up to 72
// bytes, one or two blocks), then the digest leaves as five words, one per
// transfer, from an output buffer while the next message is taken in.
// Reset (synchronous, active low) restores the initial chaining words and
// clears the byte count and the output buffer.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sha1_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sha1_pkg::t_out_item o_out
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_ADD,
        S_PAD,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [60:0] r_count;
    t_pos        r_pos;
    t_round      r_rnd;
    logic        r_pad;
    logic        r_first;
    logic        r_extra;
    logic        r_fin;
    logic [31:0] r_chain [NUM_WORDS];
    t_work       r_work;
    logic [31:0] r_dig   [NUM_WORDS];
    logic [2:0]  r_oidx;
    logic        r_obusy;

    logic        in_xfer;
    logic        out_xfer;
    logic [63:0] bit_len;
    logic [7:0]  pad_byte;
    logic [31:0] w_cur;
    t_work       work_next;
    t_sched_ctl  sched_ctl;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_obusy;
    assign out_xfer    = r_obusy && !i_out_stall;

    assign o_out.digest_word = r_dig[0];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd4);

    assign bit_len = {r_count, 3'b000};

    always_comb begin
        priority if (r_first) begin
            pad_byte = PAD_MARK;
        end else if ((r_pos >= LEN_POS) && !r_extra) begin
            pad_byte = 8'(bit_len >> {~r_pos[2:0], 3'b000});
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        sched_ctl.byte_wr  = (in_xfer && i_in.has_byte) || (r_state == S_PAD);
        sched_ctl.byte_val = (r_state == S_PAD) ? pad_byte : i_in.data_byte;
        sched_ctl.word_end = (r_pos[1:0] == 2'b11);
        sched_ctl.step     = (r_state == S_COMP);
    end

    sha1_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w_cur)
    );

    sha1_round u_round (
        .i_work  (r_work),
        .i_w     (w_cur),
        .i_round (r_rnd),
        .o_work  (work_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_rnd   <= '0;
            r_pad   <= 1'b0;
            r_first <= 1'b0;
            r_extra <= 1'b0;
            r_fin   <= 1'b0;
            r_oidx  <= '0;
            r_obusy <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_chain[i] <= H_INIT[i];
            end
        end else begin
            // drain the digest buffer one word per transfer
            if (out_xfer) begin
                for (int i = 0; i < NUM_WORDS - 1; i++) begin
                    r_dig[i] <= r_dig[i + 1];
                end
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd4) begin
                    r_obusy <= 1'b0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.is_last) begin
                            r_pad   <= 1'b1;
                            r_first <= 1'b1;
                            r_extra <= 1'b0;
                            r_fin   <= 1'b0;
                        end
                        if (i_in.has_byte) begin
                            r_count <= r_count + 61'd1;
                            r_pos   <= r_pos + t_pos'(1);
                        end
                        if (i_in.has_byte && (r_pos == LAST_POS)) begin
                            r_state <= S_COMP;
                            r_rnd   <= '0;
                            r_work  <= '{a: r_chain[0], b: r_chain[1], c: r_chain[2],
                                         d: r_chain[3], e: r_chain[4]};
                        end else if (i_in.is_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pos   <= r_pos + t_pos'(1);
                    r_first <= 1'b0;
                    // marker too late for the length: one more block follows
                    if (r_first && (r_pos >= LEN_POS) && (r_pos != LAST_POS)) begin
                        r_extra <= 1'b1;
                    end
                    if (r_pos == LAST_POS) begin
                        r_extra <= 1'b0;
                        r_fin   <= !(r_first || r_extra);
                        r_state <= S_COMP;
                        r_rnd   <= '0;
                        r_work  <= '{a: r_chain[0], b: r_chain[1], c: r_chain[2],
                                     d: r_chain[3], e: r_chain[4]};
                    end
                end
                S_COMP: begin
                    r_work <= work_next;
                    r_rnd  <= r_rnd + t_round'(1);
                    if (r_rnd == LAST_ROUND) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_chain[0] <= r_chain[0] + r_work.a;
                    r_chain[1] <= r_chain[1] + r_work.b;
                    r_chain[2] <= r_chain[2] + r_work.c;
                    r_chain[3] <= r_chain[3] + r_work.d;
                    r_chain[4] <= r_chain[4] + r_work.e;
                    priority if (r_fin) begin
                        r_state <= S_DONE;
                    end else if (r_pad) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DONE: begin
                    // hold until the previous digest has fully left
                    if (!r_obusy) begin
                        for (int i = 0; i < NUM_WORDS; i++) begin
                            r_dig[i]   <= r_chain[i];
                            r_chain[i] <= H_INIT[i];
                        end
                        r_obusy <= 1'b1;
                        r_oidx  <= '0;
                        r_count <= '0;
                        r_pos   <= '0;
                        r_pad   <= 1'b0;
                        r_fin   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sha1_digest_checker.sv */
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Watches both channels of the SHA-1 stream hasher. Each accepted input
// transfer is run through an SHA-1 predictor that holds its own chaining
// words, block buffer and byte count. Every finished message queues five
// digest words. Each output transfer is compared field by field with the
// oldest queued word.
// ----------------------------------------------------------------------------
module sha1_digest_checker
    import sha1_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out,
    output int        o_errors,
    output int        o_pending
);

    logic [4:0][31:0]  chain;
    logic [63:0][7:0]  msg_block;
    logic [60:0]       msg_bytes;
    t_out_item         digest_q[$];

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [4:0][31:0] sha1_compress_block(
        input logic [4:0][31:0] h,
        input logic [63:0][7:0] blk
    );
        logic [15:0][31:0] w;
        logic [31:0]       a, b, c, d, e, f, k, sum, x;
        logic [4:0][31:0]  res;
        int                t;
        for (t = 0; t < 16; t++) begin
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end
        a = h[0];
        b = h[1];
        c = h[2];
        d = h[3];
        e = h[4];
        for (t = 0; t < 80; t++) begin
            // roll the schedule in place over a 16-word window
            if (t >= 16) begin
                x = w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16];
                w[t%16] = rol32(x, 1);
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_00_19;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_20_39;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_40_59;
            end else begin
                f = b ^ c ^ d;
                k = K_60_79;
            end
            sum = rol32(a, 5) + f + e + k + w[t%16];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = sum;
        end
        res[0] = h[0] + a;
        res[1] = h[1] + b;
        res[2] = h[2] + c;
        res[3] = h[3] + d;
        res[4] = h[4] + e;
        return res;
    endfunction

    task automatic restart_message();
        int i;
        for (i = 0; i < 5; i++) begin
            chain[i] = H_INIT[i];
        end
        msg_bytes = '0;
    endtask

    task automatic absorb_item(input t_in_item it);
        logic [63:0] nbits;
        t_out_item   word;
        int          pos;
        int          i;
        if (it.has_byte) begin
            pos = int'(msg_bytes[5:0]);
            msg_block[pos] = it.data_byte;
            msg_bytes = msg_bytes + 1'b1;
            if (pos == 63) begin
                chain = sha1_compress_block(chain, msg_block);
            end
        end
        if (it.is_last) begin
            nbits = {msg_bytes, 3'b000};
            pos = int'(msg_bytes[5:0]);
            msg_block[pos] = PAD_MARK;
            for (i = pos + 1; i < 64; i++) begin
                msg_block[i] = 8'h00;
            end
            // no room for the length: spill into a second block
            if (pos >= 56) begin
                chain = sha1_compress_block(chain, msg_block);
                msg_block = '0;
            end
            for (i = 0; i < 8; i++) begin
                msg_block[56+i] = nbits[63-8*i -: 8];
            end
            chain = sha1_compress_block(chain, msg_block);
            for (i = 0; i < 5; i++) begin
                word.digest_word = chain[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 4);
                digest_q.push_back(word);
            end
            restart_message();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            restart_message();
            msg_block = '0;
            digest_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                absorb_item(i_in);
            end
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest transfer: word %h index %0d last %b",
                           i_out.digest_word, i_out.word_index, i_out.last_word);
                    o_errors = o_errors + 1;
                end else begin
                    want = digest_q.pop_front();
                    if (i_out.digest_word !== want.digest_word) begin
                        $error("digest_word: expected %h, actual %h",
                               want.digest_word, i_out.digest_word);
                        o_errors = o_errors + 1;
                    end
                    if (i_out.word_index !== want.word_index) begin
                        $error("word_index: expected %0d, actual %0d",
                               want.word_index, i_out.word_index);
                        o_errors = o_errors + 1;
                    end
                    if (i_out.last_word !== want.last_word) begin
                        $error("last_word: expected %b, actual %b",
                               want.last_word, i_out.last_word);
                        o_errors = o_errors + 1;
                    end
                end
            end
        end
        o_pending = digest_q.size();
    end

endmodule

/* tb/sha1_stream_hasher_tb.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Drives byte streams into the SHA-1 stream hasher: a few known messages,
// a long output hold-off that backs the block up, then random messages of
// lengths around the padding and block boundaries, with random gaps on
// both channels. A checker beside the block predicts every digest word.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb;

    import sha1_pkg::*;

    localparam int  HOLD_CYCLES  = 800;
    localparam int  TAIL_CYCLES  = 200;
    localparam int  RANDOM_ITEMS = 410;
    localparam time RUN_LIMIT    = 12 * 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    int        check_errors;
    int        digests_pending;
    int        items_sent;
    bit        quiet_tx;
    logic      hold_on;

    sha1_stream_hasher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    sha1_digest_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_item),
        .o_errors    (check_errors),
        .o_pending   (digests_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end else if (r < 19) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return $urandom_range(0, 16);
        end else if (r < 18) begin
            return $urandom_range(52, 72);
        end else if (r < 19) begin
            return $urandom_range(116, 132);
        end
        return $urandom_range(0, 2);
    endfunction

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [7:0] d, input logic has, input logic last);
        int gap;
        gap = quiet_tx ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{data_byte: d, has_byte: has, is_last: last};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit bare_end);
        int i;
        for (i = 0; i < len; i++) begin
            // odd empty transfer that the block must ignore
            if ($urandom_range(0, 19) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
            items_sent++;
        end
        if (len == 0 || bare_end) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (digests_pending != 0) @(negedge i_clk);
    endtask

    // receiver: random stalls, quiet windows and one long hold-off
    initial begin
        int  stall_left;
        int  free_left;
        bit  held;
        stall_left = 0;
        free_left  = 0;
        held       = 1'b0;
        out_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_on && !held) begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (free_left > 0) begin
                    free_left--;
                end else if ($urandom_range(0, 19) == 0) begin
                    free_left = $urandom_range(50, 300);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    initial begin
        int m;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        hold_on    = 1'b0;
        quiet_tx   = 1'b0;
        items_sent = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty message straight after reset
        send_item(8'h00, 1'b0, 1'b1);
        // transfer with no byte and no end: ignored
        send_item(8'hFF, 1'b0, 1'b0);
        // "ab" and a 0xFF byte, with the end marker riding on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        // extreme bytes, then a bare end marker with junk data
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        // empty message straight after a digest
        send_item(8'h5A, 1'b0, 1'b1);
        wait_drained();

        // hold the output off while messages keep coming, then drain
        hold_on  <= 1'b1;
        quiet_tx  = 1'b1;
        for (m = 0; m < 4; m++) begin
            send_message($urandom_range(2, 6), m[0]);
        end
        wait_drained();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            quiet_tx = ($urandom_range(0, 5) == 0);
            send_message(pick_len(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (check_errors == 0 && digests_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
